// ===== rtl/assert_macros.svh =====
// Assertion macros used by the checker file rte_checker.sv.
// No dependencies; clock and reset names are passed in by the user.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every rising edge outside reset.
`define RTE_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Checked on every rising edge, reset included.
`define RTE_ASSERT_ALWAYS(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== rtl/rte_pkg.sv =====
// Types, constants and symbol timing functions of the tristate remote encoder.
// No dependencies.
`timescale 1ns / 1ps

package rte_pkg;

   localparam int FRAME_REPEATS = 4;

   localparam logic [9:0] UNIT_RESET     = 10'd103;
   localparam logic [6:0] SHORT_UNITS    = 7'd4;
   localparam logic [6:0] LONG_UNITS     = 7'd12;
   localparam logic [6:0] SYNC_LOW_UNITS = 7'(128 - 4 - 3);
   localparam logic [3:0] SYNC_TRIT      = 4'd12;
   localparam logic [3:0] ON_OFF_TRIT    = 4'd11;
   localparam logic [1:0] LAST_REPEAT    = 2'(FRAME_REPEATS - 1);
   localparam logic [1:0] LAST_SEG_TRIT  = 2'd3;
   localparam logic [1:0] LAST_SEG_SYNC  = 2'd1;

   typedef enum logic {
      REQ_TICK  = 1'b0,
      REQ_START = 1'b1
   } req_kind_type;

   typedef struct packed {
      logic       req_type;
      logic [7:0] group;
      logic [7:0] module_req;
      logic       switch_on;
   } req_data_type;

   // Registered input item as seen by the core.
   typedef struct packed {
      logic         valid;
      req_data_type data;
   } req_stage_type;

   // Trit t is an L trit for the held command.
   function automatic logic trit_is_low(input logic [3:0] t, input logic [7:0] grp,
                                        input logic [7:0] mdl, input logic on_bit);
      logic res;
      res = 1'b0;
      if (t < 4'd4)
         res = (grp == ({4'd0, t} + 8'd1));
      else if (t < 4'd8)
         res = (mdl == ({4'd0, t} - 8'd3));
      else if (t == ON_OFF_TRIT)
         res = !on_bit;
      return res;
   endfunction

   // Length in units of segment s of trit t (sync when t is 12 or more).
   function automatic logic [6:0] seg_units(input logic [3:0] t, input logic [1:0] s,
                                            input logic [7:0] grp, input logic [7:0] mdl,
                                            input logic on_bit);
      logic [6:0] res;
      if (t >= SYNC_TRIT)
         res = (s == 2'd0) ? SHORT_UNITS : SYNC_LOW_UNITS;
      else if (s == 2'd0)
         res = SHORT_UNITS;
      else if (s == 2'd1)
         res = LONG_UNITS;
      else if (trit_is_low(t, grp, mdl, on_bit))
         res = (s == 2'd2) ? SHORT_UNITS : LONG_UNITS;
      else
         res = (s == 2'd2) ? LONG_UNITS : SHORT_UNITS;
      return res;
   endfunction

endpackage

// ===== rtl/rte_intf.sv =====
// Valid/ready channel interfaces: command/tick input, result output, unit register write.
// Depends on nothing.
`timescale 1ns / 1ps

interface rte_req_if;
   logic       valid;
   logic       ready;
   logic       req_type;
   logic [7:0] group;
   logic [7:0] module_req;
   logic       switch_on;

   modport source (output valid, req_type, group, module_req, switch_on, input ready);
   modport sink   (input valid, req_type, group, module_req, switch_on, output ready);
endinterface

interface rte_rsp_if;
   logic valid;
   logic ready;
   logic rf_level;
   logic busy_res;
   logic accepted;
   logic tx_done;

   modport source (output valid, rf_level, busy_res, accepted, tx_done, input ready);
   modport sink   (input valid, rf_level, busy_res, accepted, tx_done, output ready);
endinterface

interface rte_csr_if;
   logic       valid;
   logic       ready;
   logic [9:0] unit_us;

   modport source (output valid, unit_us, input ready);
   modport sink   (input valid, unit_us, output ready);
endinterface

// ===== rtl/rte_in_stage.sv =====
// Input register of the encoder: holds one accepted request until the core takes it.
// Depends on rte_pkg and rte_req_if.
`timescale 1ns / 1ps

module rte_in_stage (
   input  logic                   clock,
   input  logic                   reset,
   rte_req_if.sink                req_if,
   input  logic                   take,
   output rte_pkg::req_stage_type stage
);

   logic                  valid_ff, valid_in;
   rte_pkg::req_data_type data_ff, data_in;
   logic                  load;

   assign req_if.ready = !valid_ff || take;
   assign load         = req_if.valid && req_if.ready;

   always_comb begin
      valid_in = valid_ff;
      data_in  = data_ff;
      if (load) begin
         valid_in            = 1'b1;
         data_in.req_type    = req_if.req_type;
         data_in.group       = req_if.group;
         data_in.module_req  = req_if.module_req;
         data_in.switch_on   = req_if.switch_on;
      end else if (take) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

   assign stage.valid = valid_ff;
   assign stage.data  = data_ff;

endmodule

// ===== rtl/rte_core.sv =====
// Encoder core: unit register, frame/trit/segment/unit/tick counters and result register.
// Depends on rte_pkg, rte_rsp_if and rte_csr_if.
`timescale 1ns / 1ps

module rte_core (
   input  logic                   clock,
   input  logic                   reset,
   input  rte_pkg::req_stage_type stage,
   output logic                   take,
   rte_csr_if.sink                csr_if,
   rte_rsp_if.source              rsp_if
);

   logic [9:0] unit_us_ff, unit_us_in;
   logic       active_ff, active_in;
   logic [7:0] group_ff, group_in;
   logic [7:0] module_ff, module_in;
   logic       on_ff, on_in;
   logic [1:0] repeat_ff, repeat_in;
   logic [3:0] trit_ff, trit_in;
   logic [1:0] seg_ff, seg_in;
   logic [6:0] units_ff, units_in;
   logic [9:0] tick_ff, tick_in;

   logic       rsp_valid_ff, rsp_valid_in;
   logic       level_ff, level_in;
   logic       busy_ff, busy_in;
   logic       acc_ff, acc_in;
   logic       done_ff, done_in;

   logic [6:0] units_dec;
   logic [1:0] last_seg;
   logic       step;

   assign csr_if.ready = 1'b1;
   assign unit_us_in   = (csr_if.valid) ? csr_if.unit_us : unit_us_ff;

   assign take = !rsp_valid_ff || rsp_if.ready;
   assign step = stage.valid && take;

   assign units_dec = units_ff - 7'd1;
   assign last_seg  = (trit_ff >= rte_pkg::SYNC_TRIT) ? rte_pkg::LAST_SEG_SYNC
                                                       : rte_pkg::LAST_SEG_TRIT;

   always_comb begin
      active_in = active_ff;
      group_in  = group_ff;
      module_in = module_ff;
      on_in     = on_ff;
      repeat_in = repeat_ff;
      trit_in   = trit_ff;
      seg_in    = seg_ff;
      units_in  = units_ff;
      tick_in   = tick_ff;
      level_in  = 1'b0;
      busy_in   = 1'b0;
      acc_in    = 1'b0;
      done_in   = 1'b0;

      if (stage.data.req_type == rte_pkg::REQ_START) begin
         // commands never advance time; ignored while a transmission runs
         if (!active_ff) begin
            group_in  = stage.data.group;
            module_in = stage.data.module_req;
            on_in     = stage.data.switch_on;
            active_in = 1'b1;
            repeat_in = 2'd0;
            trit_in   = 4'd0;
            seg_in    = 2'd0;
            tick_in   = 10'd0;
            units_in  = rte_pkg::SHORT_UNITS;
            acc_in    = 1'b1;
         end
         busy_in  = 1'b1;
         level_in = !seg_in[0];
      end else if (active_ff) begin
         busy_in  = 1'b1;
         level_in = !seg_ff[0];
         if (tick_ff == unit_us_ff - 10'd1) begin
            tick_in  = 10'd0;
            units_in = units_dec;
            if (units_dec == 7'd0) begin
               if (seg_ff < last_seg) begin
                  seg_in = seg_ff + 2'd1;
               end else begin
                  seg_in = 2'd0;
                  if (trit_ff < rte_pkg::SYNC_TRIT) begin
                     trit_in = trit_ff + 4'd1;
                  end else begin
                     trit_in = 4'd0;
                     if (repeat_ff == rte_pkg::LAST_REPEAT) begin
                        active_in = 1'b0;
                        repeat_in = 2'd0;
                        done_in   = 1'b1;
                     end else begin
                        repeat_in = repeat_ff + 2'd1;
                     end
                  end
               end
               units_in = active_in ? rte_pkg::seg_units(trit_in, seg_in, group_ff,
                                                         module_ff, on_ff)
                                    : 7'd0;
            end
         end else begin
            tick_in = tick_ff + 10'd1;
         end
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (step)
         rsp_valid_in = 1'b1;
      else if (rsp_if.ready)
         rsp_valid_in = 1'b0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         unit_us_ff   <= rte_pkg::UNIT_RESET;
         active_ff    <= 1'b0;
         group_ff     <= 8'd0;
         module_ff    <= 8'd0;
         on_ff        <= 1'b0;
         repeat_ff    <= 2'd0;
         trit_ff      <= 4'd0;
         seg_ff       <= 2'd0;
         units_ff     <= 7'd0;
         tick_ff      <= 10'd0;
         rsp_valid_ff <= 1'b0;
      end else begin
         unit_us_ff   <= unit_us_in;
         rsp_valid_ff <= rsp_valid_in;
         if (step) begin
            active_ff <= active_in;
            group_ff  <= group_in;
            module_ff <= module_in;
            on_ff     <= on_in;
            repeat_ff <= repeat_in;
            trit_ff   <= trit_in;
            seg_ff    <= seg_in;
            units_ff  <= units_in;
            tick_ff   <= tick_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (step) begin
         level_ff <= level_in;
         busy_ff  <= busy_in;
         acc_ff   <= acc_in;
         done_ff  <= done_in;
      end
   end

   assign rsp_if.valid    = rsp_valid_ff;
   assign rsp_if.rf_level = level_ff;
   assign rsp_if.busy_res = busy_ff;
   assign rsp_if.accepted = acc_ff;
   assign rsp_if.tx_done  = done_ff;

endmodule

// ===== rtl/rf_tristate_remote_encoder_unit.sv =====
// Data path: a transfer on req_if lands in the input register; its result is then loaded
// into the result register, which drives rsp_if; while rsp_if is stalled the result waits
// there and the input register holds its request.
// Throughput: one request per cycle while rsp_if is not stalled; the counter update is a single pass per item.
// Reset: synchronous, active high; idle, counters clear, unit_us returns to 103.
// Top level of the tristate remote encoder; depends on rte_pkg, the channel
// interfaces, rte_in_stage and rte_core.
`timescale 1ns / 1ps

module rf_tristate_remote_encoder_unit (
   input  logic      clock,
   input  logic      reset,
   rte_req_if.sink   req_if,
   rte_rsp_if.source rsp_if,
   rte_csr_if.sink   csr_if
);

   rte_pkg::req_stage_type stage;
   logic                   take;

   rte_in_stage u_in_stage (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_if),
      .take   (take),
      .stage  (stage)
   );

   rte_core u_core (
      .clock  (clock),
      .reset  (reset),
      .stage  (stage),
      .take   (take),
      .csr_if (csr_if),
      .rsp_if (rsp_if)
   );

endmodule

// ===== rtl/rte_checker.sv =====
// Port-level checks of the tristate remote encoder, bound to the top level.
// Depends on assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module rte_checker (
   input logic clock,
   input logic reset,
   input logic rsp_valid,
   input logic rsp_ready,
   input logic rf_level,
   input logic busy_res,
   input logic accepted,
   input logic tx_done
);

   // a stalled result keeps its fields
   `RTE_ASSERT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready |=> rsp_valid && $stable({rf_level, busy_res, accepted, tx_done}), "rsp fields changed while stalled")

   `RTE_ASSERT(a_acc_busy, clock, reset, rsp_valid && accepted |-> busy_res && rf_level, "accepted command without busy high level")

   `RTE_ASSERT(a_done_excl, clock, reset, rsp_valid && tx_done |-> busy_res && !accepted, "tx_done outside a running transmission")

   `RTE_ASSERT(a_idle_low, clock, reset, rsp_valid && !busy_res |-> !rf_level && !tx_done, "level driven while idle")

endmodule

bind rf_tristate_remote_encoder_unit rte_checker u_rte_checker (
   .clock     (clock),
   .reset     (reset),
   .rsp_valid (rsp_if.valid),
   .rsp_ready (rsp_if.ready),
   .rf_level  (rsp_if.rf_level),
   .busy_res  (rsp_if.busy_res),
   .accepted  (rsp_if.accepted),
   .tx_done   (rsp_if.tx_done)
);

// ===== verif/testbench.sv =====
// Testbench for rf_tristate_remote_encoder_unit: drives switch commands and microsecond
// ticks, predicts the transmit level and status of every transfer, checks each result.
// Depends on rte_pkg, the channel interfaces in rte_intf.sv and the encoder RTL.
`timescale 1ns / 1ps

module testbench;

   typedef struct packed {
      logic level;
      logic busy;
      logic taken;
      logic done;
   } tx_result_type;

   localparam int STALL_LIMIT = 1000;

   logic clock;
   logic reset;

   rte_req_if req_if ();
   rte_rsp_if rsp_if ();
   rte_csr_if csr_if ();

   rf_tristate_remote_encoder_unit DUT (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_if),
      .rsp_if (rsp_if),
      .csr_if (csr_if)
   );

   rte_pkg::req_data_type pending_reqs[$];
   tx_result_type         expected_results[$];
   int                    reqs_queued;
   int                    reqs_taken;
   int                    mismatches;
   int                    sender_idle_pct;
   int                    receiver_idle_pct;
   logic                  req_fire;
   rte_pkg::req_data_type next_req;
   rte_pkg::req_data_type sampled_req;
   tx_result_type         want;

   // Encoder shadow state
   logic [9:0] unit_ticks;
   logic       tx_active;
   logic [7:0] hold_grp;
   logic [7:0] hold_mod;
   logic       hold_on;
   logic [1:0] rep_idx;
   logic [3:0] trit_idx;
   logic [1:0] seg_idx;
   logic [6:0] units_rem;
   logic [9:0] tick_cnt;

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // Segment length in units; trit 12 and above is the sync symbol.
   function automatic logic [6:0] segment_length(input logic [3:0] trit, input logic [1:0] seg);
      logic low_trit;
      if (trit >= rte_pkg::SYNC_TRIT)
         return (seg == 2'd0) ? rte_pkg::SHORT_UNITS : rte_pkg::SYNC_LOW_UNITS;
      if (trit < 4'd4)
         low_trit = (hold_grp == 8'(trit) + 8'd1);
      else if (trit < 4'd8)
         low_trit = (hold_mod == 8'(trit) - 8'd3);
      else
         low_trit = (trit == rte_pkg::ON_OFF_TRIT) && !hold_on;
      case (seg)
         2'd0: return rte_pkg::SHORT_UNITS;
         2'd1: return rte_pkg::LONG_UNITS;
         2'd2: return low_trit ? rte_pkg::SHORT_UNITS : rte_pkg::LONG_UNITS;
         default: return low_trit ? rte_pkg::LONG_UNITS : rte_pkg::SHORT_UNITS;
      endcase
   endfunction

   function automatic tx_result_type encode_step(input rte_pkg::req_data_type item);
      tx_result_type res;
      logic [1:0]    end_seg;
      res = '0;
      if (item.req_type == rte_pkg::REQ_START) begin
         if (!tx_active) begin
            hold_grp  = item.group;
            hold_mod  = item.module_req;
            hold_on   = item.switch_on;
            tx_active = 1'b1;
            rep_idx   = '0;
            trit_idx  = '0;
            seg_idx   = '0;
            tick_cnt  = '0;
            units_rem = segment_length(4'd0, 2'd0);
            res.taken = 1'b1;
         end
         // a command never advances time
         res.busy  = tx_active;
         res.level = tx_active && !seg_idx[0];
      end else if (tx_active) begin
         res.busy  = 1'b1;
         res.level = !seg_idx[0];
         if (tick_cnt == unit_ticks - 10'd1) begin
            tick_cnt  = '0;
            units_rem = units_rem - 7'd1;
            if (units_rem == '0) begin
               end_seg = (trit_idx >= rte_pkg::SYNC_TRIT) ? rte_pkg::LAST_SEG_SYNC
                                                          : rte_pkg::LAST_SEG_TRIT;
               if (seg_idx < end_seg) begin
                  seg_idx = seg_idx + 2'd1;
               end else begin
                  seg_idx = '0;
                  if (trit_idx < rte_pkg::SYNC_TRIT) begin
                     trit_idx = trit_idx + 4'd1;
                  end else begin
                     trit_idx = '0;
                     if (rep_idx == rte_pkg::LAST_REPEAT) begin
                        tx_active = 1'b0;
                        rep_idx   = '0;
                        res.done  = 1'b1;
                     end else begin
                        rep_idx = rep_idx + 2'd1;
                     end
                  end
               end
               units_rem = tx_active ? segment_length(trit_idx, seg_idx) : 7'd0;
            end
         end else begin
            tick_cnt = tick_cnt + 10'd1;
         end
      end
      return res;
   endfunction

   task automatic report_mismatch(input string what, input int got, input int exp_val);
      mismatches++;
      $display("ERROR %0t: %s got %0d expected %0d", $time, what, got, exp_val);
   endtask

   // Driver: one item per transfer, random gaps on the sender and receiver side.
   always @(negedge clock) begin
      if (reset) begin
         req_if.valid <= 1'b0;
         rsp_if.ready <= 1'b0;
      end else begin
         if (!req_if.valid || req_fire) begin
            if (pending_reqs.size() != 0 && $urandom_range(0, 99) >= sender_idle_pct) begin
               next_req = pending_reqs.pop_front();
               req_if.valid      <= 1'b1;
               req_if.req_type   <= next_req.req_type;
               req_if.group      <= next_req.group;
               req_if.module_req <= next_req.module_req;
               req_if.switch_on  <= next_req.switch_on;
            end else begin
               req_if.valid <= 1'b0;
            end
         end
         rsp_if.ready <= ($urandom_range(0, 99) >= receiver_idle_pct);
      end
   end

   // Monitor: register writes, accepted items into the predictor, results against it.
   always @(posedge clock) begin
      if (reset) begin
         req_fire   <= 1'b0;
         reqs_taken <= 0;
         unit_ticks = rte_pkg::UNIT_RESET;
         tx_active  = 1'b0;
         hold_grp   = '0;
         hold_mod   = '0;
         hold_on    = 1'b0;
         rep_idx    = '0;
         trit_idx   = '0;
         seg_idx    = '0;
         units_rem  = '0;
         tick_cnt   = '0;
      end else begin
         if (csr_if.valid && csr_if.ready) unit_ticks = csr_if.unit_us;
         req_fire <= req_if.valid && req_if.ready;
         if (req_if.valid && req_if.ready) begin
            sampled_req.req_type   = req_if.req_type;
            sampled_req.group      = req_if.group;
            sampled_req.module_req = req_if.module_req;
            sampled_req.switch_on  = req_if.switch_on;
            expected_results.push_back(encode_step(sampled_req));
            reqs_taken <= reqs_taken + 1;
         end
         if (rsp_if.valid && rsp_if.ready) begin
            if (expected_results.size() == 0) begin
               report_mismatch("result transfer with nothing pending", 1, 0);
            end else begin
               want = expected_results.pop_front();
               if (rsp_if.rf_level !== want.level)
                  report_mismatch("rf_level", rsp_if.rf_level, want.level);
               if (rsp_if.busy_res !== want.busy)
                  report_mismatch("busy_res", rsp_if.busy_res, want.busy);
               if (rsp_if.accepted !== want.taken)
                  report_mismatch("accepted", rsp_if.accepted, want.taken);
               if (rsp_if.tx_done !== want.done)
                  report_mismatch("tx_done", rsp_if.tx_done, want.done);
            end
         end
      end
   end

   // Watchdog: ends the run when no channel has moved for too long.
   initial begin
      int quiet_cycles;
      quiet_cycles = 0;
      while (quiet_cycles < STALL_LIMIT) begin
         @(posedge clock);
         if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready) ||
             (csr_if.valid && csr_if.ready))
            quiet_cycles = 0;
         else
            quiet_cycles++;
      end
      $display("Simulation FAILED");
      $finish;
   end

   task automatic queue_req(input rte_pkg::req_kind_type kind, input logic [7:0] grp,
                            input logic [7:0] mdl, input logic on_bit);
      rte_pkg::req_data_type item;
      item.req_type   = kind;
      item.group      = grp;
      item.module_req = mdl;
      item.switch_on  = on_bit;
      pending_reqs.push_back(item);
      reqs_queued++;
   endtask

   // Mostly a valid position (1 to 4), sometimes anything the field holds.
   function automatic logic [7:0] pick_address();
      if ($urandom_range(0, 99) < 70) return 8'($urandom_range(1, 4));
      return 8'($urandom_range(0, 255));
   endfunction

   // Ticks carry random junk in the ignored fields; when with_cmds is set, stray commands are mixed in.
   task automatic queue_ticks(input int count, input bit with_cmds);
      for (int i = 0; i < count; i++) begin
         if (with_cmds && $urandom_range(0, 99) < 3)
            queue_req(rte_pkg::REQ_START, 8'($urandom), 8'($urandom), 1'($urandom));
         queue_req(rte_pkg::REQ_TICK, 8'($urandom), 8'($urandom), 1'($urandom));
      end
   endtask

   task automatic wait_drained();
      do @(negedge clock);
      while (reqs_taken != reqs_queued || expected_results.size() != 0);
      repeat (4) @(negedge clock);
   endtask

   task automatic write_unit(input logic [9:0] value);
      @(negedge clock);
      csr_if.valid   <= 1'b1;
      csr_if.unit_us <= value;
      do @(posedge clock);
      while (!csr_if.ready);
      @(negedge clock);
      csr_if.valid <= 1'b0;
   endtask

   initial begin
      reset             = 1'b1;
      req_if.valid      = 1'b0;
      req_if.req_type   = rte_pkg::REQ_TICK;
      req_if.group      = '0;
      req_if.module_req = '0;
      req_if.switch_on  = 1'b0;
      rsp_if.ready      = 1'b0;
      csr_if.valid      = 1'b0;
      csr_if.unit_us    = '0;
      reqs_queued       = 0;
      mismatches        = 0;
      sender_idle_pct   = 24;
      receiver_idle_pct = 52;
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // idle ticks change nothing, also at the extreme unit settings
      queue_ticks(3, 1'b0);
      wait_drained();
      write_unit(10'd1023);
      queue_ticks(4, 1'b0);
      wait_drained();
      write_unit(10'd0);
      queue_ticks(4, 1'b0);
      wait_drained();

      // one unit per tick: a whole frame with its sync, then into the next repeat
      write_unit(10'd1);
      queue_req(rte_pkg::REQ_START, pick_address(), pick_address(), 1'($urandom));
      queue_ticks(540, 1'b1);
      wait_drained();

      // longer units mid-transmission; the tick counter stays below the new compare value
      sender_idle_pct   = 52;
      receiver_idle_pct = 24;
      write_unit(10'd2);
      queue_ticks(70, 1'b1);
      wait_drained();

      sender_idle_pct   = 0;
      receiver_idle_pct = 0;
      write_unit(10'd4);
      queue_ticks(60, 1'b1);
      wait_drained();

      repeat (10) @(negedge clock);
      if (mismatches == 0)
         $display("Simulation PASSED");
      else
         $display("Simulation FAILED");
      $finish;
   end

endmodule

// ===== sim.f =====
+incdir+rtl
rtl/rte_pkg.sv
rtl/rte_intf.sv
rtl/rte_in_stage.sv
rtl/rte_core.sv
rtl/rf_tristate_remote_encoder_unit.sv
rtl/rte_checker.sv
verif/testbench.sv
